// File: rtl/nbt_pkg.sv
package nbt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BYTES     = 8;

    localparam int KEY_W  = KEY_BYTES * 8;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int TIME_W = 32;
    localparam int RSSI_W = 8;

    localparam int ACTION_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int REMOVED_W = 5;
    localparam int TRACKED_W = 5;

    localparam logic [TIME_W-1:0] TTL_RESET = 32'd30000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_UPDATED  = 3'd0,
        ACT_INSERTED = 3'd1,
        ACT_REPLACED = 3'd2,
        ACT_SWEPT    = 3'd3,
        ACT_DROPPED  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RSSI_W-1:0] strength;
        logic [TIME_W-1:0] heard;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                 valid;
        action_t              action;
        logic [SLOT_W-1:0]    slot;
        logic [REMOVED_W-1:0] removed;
        logic [TRACKED_W-1:0] tracked;
    } result_t;

    // keep bytes up to the first zero byte, zero the rest
    function automatic logic [KEY_W-1:0] canon_key(input logic [63:0] raw);
        logic [KEY_W-1:0] k;
        logic             live;
        k    = '0;
        live = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'h00) begin
                live = 1'b0;
            end
            if (live) begin
                k[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return k;
    endfunction

endpackage

// File: rtl/neighbor_table_with_aging_unit.sv
// Channel   Direction  Beat contents
// s_        in         cmd, device_key, rssi, now_ms
// m_        out        action, slot, removed_count, tracked_count
// cfg_      in         ttl_ms
//
// Each item passes from acceptance to its result in order: one read per entry through the
// entry memory (separate read and write ports), then decide/write, then output.
// A new item is accepted once the previous one has moved into the output register.
// Reset is synchronous, active low; it clears all valid marks and sets ttl_ms to 30000.
// A stalled m_ side holds the result; the next item may be accepted meanwhile.
module neighbor_table_with_aging_unit
    import nbt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [63:0]          s_device_key,
    input  logic signed [7:0]    s_rssi,
    input  logic [TIME_W-1:0]    s_now_ms,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ACTION_W-1:0]  m_action,
    output logic [SLOT_W-1:0]    m_slot,
    output logic [REMOVED_W-1:0] m_removed_count,
    output logic [TRACKED_W-1:0] m_tracked_count,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIME_W-1:0]    cfg_ttl_ms
);

    logic [TIME_W-1:0]    ttl_reg;
    logic                 m_valid_reg;
    action_t              m_action_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [REMOVED_W-1:0] m_removed_reg;
    logic [TRACKED_W-1:0] m_tracked_reg;

    logic     idle;
    logic     start;
    logic     out_free;
    mem_req_t mem_req;
    entry_t   rd_data;
    result_t  result;

    assign cfg_ready = 1'b1;
    assign s_ready   = idle;
    assign start     = s_valid && idle;
    assign out_free  = !m_valid_reg || m_ready;

    nbt_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    nbt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .item_cmd  (s_cmd),
        .item_key  (s_device_key),
        .item_rssi (s_rssi),
        .item_now  (s_now_ms),
        .ttl       (ttl_reg),
        .out_free  (out_free),
        .rd_data   (rd_data),
        .idle      (idle),
        .mem_req   (mem_req),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg     <= TTL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                ttl_reg <= cfg_ttl_ms;
            end
            if (result.valid && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid && out_free) begin
            m_action_reg  <= result.action;
            m_slot_reg    <= result.slot;
            m_removed_reg <= result.removed;
            m_tracked_reg <= result.tracked;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_action        = m_action_reg;
    assign m_slot          = m_slot_reg;
    assign m_removed_count = m_removed_reg;
    assign m_tracked_count = m_tracked_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    a_sweep_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_action_reg == ACT_SWEPT)) |-> (m_slot == '0))
        else $error("sweep result carries a slot");

    a_sighting_no_removal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_action_reg != ACT_SWEPT)) |-> (m_removed_count == '0))
        else $error("sighting result reports removals");

    a_drop_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_action_reg == ACT_DROPPED))
            |-> (m_tracked_count == TRACKED_W'(TABLE_ENTRIES)))
        else $error("drop with a free slot");
`endif

endmodule

// File: rtl/nbt_mem.sv
module nbt_mem
    import nbt_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/nbt_ctrl.sv
module nbt_ctrl
    import nbt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              item_cmd,
    input  logic [63:0]       item_key,
    input  logic [RSSI_W-1:0] item_rssi,
    input  logic [TIME_W-1:0] item_now,
    input  logic [TIME_W-1:0] ttl,
    input  logic              out_free,
    input  entry_t            rd_data,
    output logic              idle,
    output mem_req_t          mem_req,
    output result_t           result
);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  scan_reg;
    logic              chk_vld_reg;
    logic [IDX_W-1:0]  chk_idx_reg;

    logic              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [RSSI_W-1:0] rssi_reg;
    logic [TIME_W-1:0] now_reg;

    logic              hit_found_reg, free_found_reg, old_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg, free_idx_reg, old_idx_reg;
    logic [TIME_W-1:0] best_reg;
    logic [CNT_W-1:0]  removed_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    action_t           act_reg, act_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;

    logic              e_valid;
    logic [TIME_W-1:0] age;
    logic              stale;
    logic              remove_hit;
    logic              rd_en;
    logic              wr_en;
    logic              set_valid;
    logic [IDX_W-1:0]  wr_idx;

    assign e_valid    = valid_reg[chk_idx_reg];
    assign age        = now_reg - rd_data.heard;
    assign stale      = age > ttl;
    assign remove_hit = chk_vld_reg && cmd_reg && e_valid && stale;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idle           = 1'b0;
        rd_en          = 1'b0;
        result.valid   = 1'b0;
        result.action  = act_reg;
        result.slot    = SLOT_W'(slot_reg);
        result.removed = REMOVED_W'(removed_reg);
        result.tracked = TRACKED_W'(count_reg);
        case (state_reg)
            ST_IDLE:   idle = 1'b1;
            ST_SCAN:   rd_en = 1'b1;
            ST_LAST:   idle = 1'b0;
            ST_DECIDE: idle = 1'b0;
            ST_DONE:   result.valid = 1'b1;
            default:   idle = 1'b0;
        endcase
    end

    always_comb begin
        act_next  = ACT_DROPPED;
        slot_next = '0;
        wr_en     = 1'b0;
        set_valid = 1'b0;
        wr_idx    = '0;
        if (cmd_reg) begin
            act_next = ACT_SWEPT;
        end else if (hit_found_reg) begin
            act_next = ACT_UPDATED;
            wr_idx   = hit_idx_reg;
            wr_en    = 1'b1;
        end else if (free_found_reg) begin
            act_next  = ACT_INSERTED;
            wr_idx    = free_idx_reg;
            wr_en     = 1'b1;
            set_valid = 1'b1;
        end else if (old_found_reg) begin
            act_next = ACT_REPLACED;
            wr_idx   = old_idx_reg;
            wr_en    = 1'b1;
        end
        slot_next = wr_idx;
    end

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (remove_hit) begin
            valid_next[chk_idx_reg] = 1'b0;
            count_next              = count_reg - CNT_W'(1);
        end
        if ((state_reg == ST_DECIDE) && set_valid) begin
            valid_next[wr_idx] = 1'b1;
            count_next         = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            chk_vld_reg    <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= rd_en;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            if (start) begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                old_found_reg  <= 1'b0;
            end else if (chk_vld_reg && !cmd_reg) begin
                if (e_valid && !hit_found_reg && (rd_data.key == key_reg)) begin
                    hit_found_reg <= 1'b1;
                end
                if (e_valid && (rd_data.heard < best_reg)) begin
                    old_found_reg <= 1'b1;
                end
                if (!e_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg <= scan_reg;
        if (start) begin
            cmd_reg     <= item_cmd;
            key_reg     <= canon_key(item_key);
            rssi_reg    <= item_rssi;
            now_reg     <= item_now;
            scan_reg    <= '0;
            best_reg    <= '1;
            removed_reg <= '0;
        end else begin
            if (rd_en) begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            if (remove_hit) begin
                removed_reg <= removed_reg + CNT_W'(1);
            end
            if (chk_vld_reg && !cmd_reg) begin
                if (e_valid && !hit_found_reg && (rd_data.key == key_reg)) begin
                    hit_idx_reg <= chk_idx_reg;
                end
                if (e_valid && (rd_data.heard < best_reg)) begin
                    best_reg    <= rd_data.heard;
                    old_idx_reg <= chk_idx_reg;
                end
                if (!e_valid && !free_found_reg) begin
                    free_idx_reg <= chk_idx_reg;
                end
            end
        end
        if (state_reg == ST_DECIDE) begin
            act_reg  <= act_next;
            slot_reg <= slot_next;
        end
    end

    assign mem_req.rd_en            = rd_en;
    assign mem_req.rd_addr          = scan_reg;
    assign mem_req.wr_en            = wr_en && (state_reg == ST_DECIDE);
    assign mem_req.wr_addr          = wr_idx;
    assign mem_req.wr_data.key      = key_reg;
    assign mem_req.wr_data.strength = rssi_reg;
    assign mem_req.wr_data.heard    = now_reg;

endmodule
